// ----- rtl/resonance_helicity_amplitudes_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the helicity amplitude block, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef RESONANCE_HELICITY_AMPLITUDES_MACROS_SVH
`define RESONANCE_HELICITY_AMPLITUDES_MACROS_SVH

// same-cycle implication
`define RHA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rha assertion failed");

// next-cycle implication
`define RHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rha assertion failed");

`endif

// ----- rtl/rha_pkg.sv -----
// ----------------------------------------------------------------------------
// rha_pkg
// Types, coefficients, fixed-point helpers and the resonance decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rha_pkg;

    localparam int PIPE_DEPTH = 8;

    localparam logic [4:0] M_P33_1232 = 5'd0;
    localparam logic [4:0] M_S11_1535 = 5'd1;
    localparam logic [4:0] M_D13_1520 = 5'd2;
    localparam logic [4:0] M_S11_1650 = 5'd3;
    localparam logic [4:0] M_D13_1700 = 5'd4;
    localparam logic [4:0] M_D15_1675 = 5'd5;
    localparam logic [4:0] M_S31_1620 = 5'd6;
    localparam logic [4:0] M_D33_1700 = 5'd7;
    localparam logic [4:0] M_P11_1440 = 5'd8;
    localparam logic [4:0] M_P33_1600 = 5'd9;
    localparam logic [4:0] M_P13_1720 = 5'd10;
    localparam logic [4:0] M_F15_1680 = 5'd11;
    localparam logic [4:0] M_P31_1910 = 5'd12;
    localparam logic [4:0] M_P33_1920 = 5'd13;
    localparam logic [4:0] M_F35_1905 = 5'd14;
    localparam logic [4:0] M_F37_1950 = 5'd15;
    localparam logic [4:0] M_P11_1710 = 5'd16;
    localparam logic [4:0] M_F17_1970 = 5'd17;
    localparam logic [4:0] MODE_LAST  = M_F17_1970;

    localparam logic [2:0] A_VM3 = 3'd0;
    localparam logic [2:0] A_VM1 = 3'd1;
    localparam logic [2:0] A_VL  = 3'd2;
    localparam logic [2:0] A_AM3 = 3'd3;
    localparam logic [2:0] A_AM1 = 3'd4;
    localparam logic [2:0] A_AL  = 3'd5;

    localparam logic [17:0] C_SQRT6   = 18'd160530;
    localparam logic [17:0] C_SQRT2   = 18'd92681;
    localparam logic [17:0] C_2SQRT2  = 18'd185363;
    localparam logic [17:0] C_SQRT3   = 18'd113512;
    localparam logic [17:0] C_SQ2_3   = 18'd53510;
    localparam logic [17:0] C_SQ3_2   = 18'd80265;
    localparam logic [17:0] C_3_SQ2   = 18'd139023;
    localparam logic [17:0] C_2_SQ3   = 18'd75674;
    localparam logic [17:0] C_1_SQ24  = 18'd13377;
    localparam logic [17:0] C_1_SQ6   = 18'd26755;
    localparam logic [17:0] C_3_SQ40  = 18'd31086;
    localparam logic [17:0] C_1_SQ120 = 18'd5983;
    localparam logic [17:0] C_1_SQ30  = 18'd11965;
    localparam logic [17:0] C_SQ3_20  = 18'd25382;
    localparam logic [17:0] C_SQ3_40  = 18'd17948;
    localparam logic [17:0] C_SQ3_10  = 18'd35896;
    localparam logic [17:0] C_1_SQ3   = 18'd37837;
    localparam logic [17:0] C_5_12SQ3 = 18'd47297;
    localparam logic [17:0] C_1_SQ2   = 18'd46341;
    localparam logic [17:0] C_SQ27_40 = 18'd53843;
    localparam logic [17:0] C_SQ5_12  = 18'd42303;
    localparam logic [17:0] C_SQ18_20 = 18'd62173;
    localparam logic [17:0] C_3_SQ20  = 18'd43963;
    localparam logic [17:0] C_SQ5_8   = 18'd51811;
    localparam logic [17:0] C_1_SQ15  = 18'd16921;
    localparam logic [17:0] C_SQ4_15  = 18'd33843;
    localparam logic [17:0] C_1_SQ5   = 18'd29309;
    localparam logic [17:0] C_SQ18_35 = 18'd46998;
    localparam logic [17:0] C_1_SQ35  = 18'd11078;
    localparam logic [17:0] C_2_SQ35  = 18'd22155;
    localparam logic [17:0] C_SQ2_7   = 18'd35030;
    localparam logic [17:0] C_SQ6_35  = 18'd27134;
    localparam logic [17:0] C_2SQ6_35 = 18'd54269;
    localparam logic [17:0] C_SQ3_8   = 18'd40132;
    localparam logic [17:0] C_H1_SQ7  = 18'd12385;
    localparam logic [17:0] C_HSQ3_35 = 18'd9593;
    localparam logic [17:0] C_HSQ6_35 = 18'd13567;

    localparam logic signed [31:0] FX_ONE = 32'sd65536;
    localparam logic signed [31:0] LIM32  = 32'sd2147483647;

    typedef enum logic [4:0] {
        OP_ONE, OP_RV, OP_RA, OP_TV, OP_TA, OP_LAM, OP_SM, OP_CM,
        OP_LL, OP_LC2, OP_LC3, OP_LC5,
        OP_W2, OP_W3, OP_W4, OP_M2, OP_M4, OP_W125, OP_W512, OP_Q
    } t_opnd;

    typedef struct packed {
        logic signed [23:0] rv;
        logic signed [23:0] ra;
        logic signed [23:0] tv;
        logic signed [23:0] ta;
        logic signed [23:0] lam;
        logic signed [23:0] sm;
        logic signed [23:0] cm;
        logic signed [31:0] ll;
        logic signed [31:0] lc2;
        logic signed [31:0] lc3;
        logic signed [31:0] lc5;
    } t_bus;

    typedef struct packed {
        logic signed [18:0] w2;
        logic signed [18:0] w3;
        logic signed [18:0] w4;
        logic signed [18:0] m2;
        logic signed [18:0] m4;
        logic signed [18:0] w125;
        logic signed [18:0] w512;
        logic signed [18:0] q;
    } t_wts;

    typedef struct packed {
        logic [17:0] coef;
        logic        neg;
        t_opnd       x;
        t_opnd       y;
        t_opnd       z;
    } t_term;

    typedef struct packed {
        t_term [1:0] trm;
        t_opnd       post;
    } t_amp;

    typedef struct packed {
        t_amp [5:0] amp;
    } t_ctrl;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = LIM32;
        end else if (v < -48'sd2147483647) begin
            r = -LIM32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = LIM32;
        end else if (v < -33'sd2147483647) begin
            r = -LIM32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q.16 product, rounded to nearest with ties away from zero, saturated
    function automatic logic signed [31:0] fx(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = p + (p[63] ? 64'sd32767 : 64'sd32768);
        return sat48(signed'(r[63:16]));
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -32'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sel_wt(input t_opnd op, input t_wts w);
        logic signed [31:0] r;
        case (op)
            OP_W2:   r = 32'(w.w2);
            OP_W3:   r = 32'(w.w3);
            OP_W4:   r = 32'(w.w4);
            OP_M2:   r = 32'(w.m2);
            OP_M4:   r = 32'(w.m4);
            OP_W125: r = 32'(w.w125);
            OP_W512: r = 32'(w.w512);
            OP_Q:    r = 32'(w.q);
            default: r = FX_ONE;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sel(input t_opnd op, input t_bus b,
                                               input t_wts w);
        logic signed [31:0] r;
        case (op)
            OP_RV:   r = 32'(b.rv);
            OP_RA:   r = 32'(b.ra);
            OP_TV:   r = 32'(b.tv);
            OP_TA:   r = 32'(b.ta);
            OP_LAM:  r = 32'(b.lam);
            OP_SM:   r = 32'(b.sm);
            OP_CM:   r = 32'(b.cm);
            OP_LL:   r = b.ll;
            OP_LC2:  r = b.lc2;
            OP_LC3:  r = b.lc3;
            OP_LC5:  r = b.lc5;
            default: r = sel_wt(op, w);
        endcase
        return r;
    endfunction

    function automatic t_term term(input logic [17:0] coef, input logic neg,
                                   input t_opnd x, input t_opnd y, input t_opnd z);
        t_term t;
        t.coef = coef;
        t.neg  = neg;
        t.x    = x;
        t.y    = y;
        t.z    = z;
        return t;
    endfunction

    function automatic logic is_odd(input logic [4:0] mode);
        logic r;
        case (mode) inside
            M_P33_1232, M_S11_1535, M_S11_1650, M_D15_1675, M_S31_1620,
            M_P33_1600, M_P13_1720, M_P33_1920, M_F37_1950, M_F17_1970: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_ctrl decode(input logic [4:0] mode);
        t_ctrl c;
        c = '0;
        unique case (mode)
            M_P33_1232: begin
                c.amp[A_VM3].trm[0] = term(C_SQRT6, 1'b1, OP_RV, OP_W2, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_SQRT2, 1'b1, OP_RV, OP_W2, OP_ONE);
                c.amp[A_AM3].trm[0] = term(C_SQRT6, 1'b0, OP_RA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQRT2, 1'b0, OP_RA, OP_ONE, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_2SQRT2, 1'b1, OP_CM, OP_ONE, OP_ONE);
            end
            M_S11_1535: begin
                c.amp[A_VM1].trm[0] = term(C_SQRT3, 1'b0, OP_TV, OP_W2, OP_ONE);
                c.amp[A_VM1].trm[1] = term(C_SQ2_3, 1'b0, OP_LAM, OP_RV, OP_W3);
                c.amp[A_VL].trm[0]  = term(C_SQ3_2, 1'b0, OP_LAM, OP_SM, OP_M2);
                c.amp[A_AM1].trm[0] = term(C_SQRT3, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_SQ2_3, 1'b1, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ2_3, 1'b1, OP_LC3, OP_ONE, OP_ONE);
            end
            M_D13_1520: begin
                c.amp[A_VM3].trm[0] = term(C_3_SQ2, 1'b0, OP_TV, OP_W2, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_SQ3_2, 1'b0, OP_TV, OP_W2, OP_ONE);
                c.amp[A_VM1].trm[1] = term(C_2_SQ3, 1'b1, OP_LAM, OP_RV, OP_W3);
                c.amp[A_VL].trm[0]  = term(C_SQRT3, 1'b1, OP_LAM, OP_SM, OP_M2);
                c.amp[A_AM3].trm[0] = term(C_3_SQ2, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQ3_2, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_2_SQ3, 1'b0, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_2_SQ3, 1'b0, OP_LAM, OP_CM, OP_ONE);
            end
            M_S11_1650: begin
                c.amp[A_VM1].trm[0] = term(C_1_SQ24, 1'b1, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_1_SQ24, 1'b1, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_1_SQ6, 1'b0, OP_LC3, OP_ONE, OP_ONE);
            end
            M_D13_1700: begin
                c.amp[A_VM3].trm[0] = term(C_3_SQ40, 1'b1, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_1_SQ120, 1'b1, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_AM3].trm[0] = term(C_3_SQ40, 1'b1, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_1_SQ120, 1'b1, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_1_SQ30, 1'b0, OP_LAM, OP_CM, OP_ONE);
            end
            M_D15_1675: begin
                c.amp[A_VM3].trm[0] = term(C_SQ3_20, 1'b0, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_SQ3_40, 1'b0, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_AM3].trm[0] = term(C_SQ3_20, 1'b0, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQ3_40, 1'b0, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ3_10, 1'b1, OP_LAM, OP_CM, OP_ONE);
            end
            M_S31_1620: begin
                c.amp[A_VM1].trm[0] = term(C_SQRT3, 1'b0, OP_TV, OP_ONE, OP_ONE);
                c.amp[A_VM1].trm[1] = term(C_1_SQ6, 1'b1, OP_RV, OP_LAM, OP_ONE);
                c.amp[A_VM1].post   = OP_W2;
                c.amp[A_VL].trm[0]  = term(C_SQ3_2, 1'b1, OP_LAM, OP_SM, OP_W2);
                c.amp[A_AM1].trm[0] = term(C_SQRT3, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_1_SQ6, 1'b0, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_1_SQ6, 1'b0, OP_LC3, OP_ONE, OP_ONE);
            end
            M_D33_1700: begin
                c.amp[A_VM3].trm[0] = term(C_3_SQ2, 1'b0, OP_TV, OP_W2, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_SQ3_2, 1'b0, OP_TV, OP_ONE, OP_ONE);
                c.amp[A_VM1].trm[1] = term(C_1_SQ3, 1'b0, OP_LAM, OP_RV, OP_ONE);
                c.amp[A_VM1].post   = OP_W2;
                c.amp[A_VL].trm[0]  = term(C_SQRT3, 1'b0, OP_LAM, OP_SM, OP_W2);
                c.amp[A_AM3].trm[0] = term(C_3_SQ2, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQ3_2, 1'b1, OP_TA, OP_ONE, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_1_SQ3, 1'b1, OP_LAM, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_1_SQ3, 1'b1, OP_LAM, OP_CM, OP_ONE);
            end
            M_P11_1440: begin
                c.amp[A_VM1].trm[0] = term(C_SQRT3, 1'b1, OP_LL, OP_RV, OP_W512);
                c.amp[A_VL].trm[0]  = term(C_SQRT3, 1'b1, OP_LL, OP_SM, OP_Q);
                c.amp[A_AM1].trm[0] = term(C_5_12SQ3, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_5_12SQ3, 1'b0, OP_LAM, OP_LC2, OP_ONE);
            end
            M_P33_1600: begin
                c.amp[A_VM3].trm[0] = term(C_1_SQ2, 1'b0, OP_LL, OP_RV, OP_W2);
                c.amp[A_VM1].trm[0] = term(C_1_SQ6, 1'b0, OP_LL, OP_RV, OP_W2);
                c.amp[A_AM3].trm[0] = term(C_1_SQ2, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_1_SQ6, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ2_3, 1'b0, OP_LAM, OP_LC2, OP_ONE);
            end
            M_P13_1720: begin
                c.amp[A_VM3].trm[0] = term(C_3_SQ40, 1'b0, OP_LAM, OP_TV, OP_W4);
                c.amp[A_VM1].trm[0] = term(C_SQ27_40, 1'b1, OP_LAM, OP_TV, OP_W4);
                c.amp[A_VM1].trm[1] = term(C_SQ5_12, 1'b1, OP_LL, OP_RV, OP_W125);
                c.amp[A_VL].trm[0]  = term(C_SQ3_20, 1'b0, OP_LL, OP_SM, OP_W4);
                c.amp[A_AM3].trm[0] = term(C_3_SQ40, 1'b1, OP_LAM, OP_TA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQ27_40, 1'b0, OP_LAM, OP_TA, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_SQ5_12, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ5_12, 1'b0, OP_LAM, OP_LC5, OP_ONE);
            end
            M_F15_1680: begin
                c.amp[A_VM3].trm[0] = term(C_SQ18_20, 1'b1, OP_LAM, OP_TV, OP_W4);
                c.amp[A_VM1].trm[0] = term(C_3_SQ20, 1'b1, OP_LAM, OP_TV, OP_W4);
                c.amp[A_VM1].trm[1] = term(C_SQ5_8, 1'b0, OP_LL, OP_RV, OP_W125);
                c.amp[A_VL].trm[0]  = term(C_3_SQ40, 1'b0, OP_LL, OP_SM, OP_M4);
                c.amp[A_AM3].trm[0] = term(C_SQ18_20, 1'b0, OP_LAM, OP_TA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_3_SQ20, 1'b0, OP_LAM, OP_TA, OP_ONE);
                c.amp[A_AM1].trm[1] = term(C_SQ5_8, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ5_8, 1'b1, OP_LL, OP_CM, OP_ONE);
            end
            M_P31_1910: begin
                c.amp[A_VM1].trm[0] = term(C_1_SQ15, 1'b1, OP_LL, OP_RV, OP_W2);
                c.amp[A_AM1].trm[0] = term(C_1_SQ15, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ4_15, 1'b1, OP_LAM, OP_LC5, OP_ONE);
            end
            M_P33_1920: begin
                c.amp[A_VM3].trm[0] = term(C_1_SQ5, 1'b1, OP_LL, OP_RV, OP_W2);
                c.amp[A_VM1].trm[0] = term(C_1_SQ15, 1'b0, OP_LL, OP_RV, OP_W2);
                c.amp[A_AM3].trm[0] = term(C_1_SQ5, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_1_SQ15, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_SQ4_15, 1'b0, OP_LAM, OP_LC5, OP_ONE);
            end
            M_F35_1905: begin
                c.amp[A_VM3].trm[0] = term(C_SQ18_35, 1'b0, OP_LL, OP_RV, OP_W2);
                c.amp[A_VM1].trm[0] = term(C_1_SQ35, 1'b0, OP_LL, OP_RV, OP_W2);
                c.amp[A_AM3].trm[0] = term(C_SQ18_35, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_1_SQ35, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_2_SQ35, 1'b0, OP_LL, OP_CM, OP_ONE);
            end
            M_F37_1950: begin
                c.amp[A_VM3].trm[0] = term(C_SQ2_7, 1'b1, OP_LL, OP_RV, OP_W2);
                c.amp[A_VM1].trm[0] = term(C_SQ6_35, 1'b1, OP_LL, OP_RV, OP_W2);
                c.amp[A_AM3].trm[0] = term(C_SQ2_7, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_SQ6_35, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_2SQ6_35, 1'b1, OP_LL, OP_CM, OP_ONE);
            end
            M_P11_1710: begin
                c.amp[A_VM1].trm[0] = term(C_1_SQ6, 1'b0, OP_LL, OP_RV, OP_W3);
                c.amp[A_VL].trm[0]  = term(C_SQ3_8, 1'b0, OP_LL, OP_SM, OP_M2);
                c.amp[A_AM1].trm[0] = term(C_1_SQ6, 1'b1, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_1_SQ6, 1'b1, OP_LAM, OP_LC2, OP_ONE);
            end
            M_F17_1970: begin
                c.amp[A_VM3].trm[0] = term(C_H1_SQ7, 1'b0, OP_LL, OP_RV, OP_ONE);
                c.amp[A_VM1].trm[0] = term(C_HSQ3_35, 1'b0, OP_LL, OP_RV, OP_ONE);
                c.amp[A_AM3].trm[0] = term(C_H1_SQ7, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AM1].trm[0] = term(C_HSQ3_35, 1'b0, OP_LL, OP_RA, OP_ONE);
                c.amp[A_AL].trm[0]  = term(C_HSQ6_35, 1'b0, OP_LL, OP_CM, OP_ONE);
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rha_front.sv -----
// ----------------------------------------------------------------------------
// rha_front
// Operand stages: lambda products, lambda-C minus B terms, weak factors and
// per-resonance lane control.
// ----------------------------------------------------------------------------
`default_nettype none

module rha_front (
    input  logic                  i_clk,
    input  logic [4:0]            i_mode,
    input  logic signed [23:0]    i_vector_r,
    input  logic signed [23:0]    i_axial_r,
    input  logic signed [23:0]    i_vector_t,
    input  logic signed [23:0]    i_axial_t,
    input  logic signed [23:0]    i_lambda_factor,
    input  logic signed [23:0]    i_s_minus,
    input  logic signed [23:0]    i_c_minus,
    input  logic signed [23:0]    i_b_minus,
    input  logic [15:0]           i_sin2,
    output rha_pkg::t_bus         o_bus,
    output rha_pkg::t_ctrl        o_ctrl,
    output rha_pkg::t_wts         o_wts
);
    import rha_pkg::*;

    logic [4:0]         r1_mode;
    logic signed [23:0] r1_rv, r1_ra, r1_tv, r1_ta, r1_lam, r1_sm, r1_cm, r1_bm;
    logic signed [31:0] r1_ll, r1_lc;
    t_bus               r_bus;
    t_ctrl              r_ctrl;
    t_wts               r_wts;

    logic signed [19:0] w_s;
    logic [19:0]        w_x125;
    logic [41:0]        w_prod;
    logic [17:0]        w_q5;

    assign w_s    = signed'({4'd0, i_sin2});
    assign w_x125 = 20'(i_sin2) * 20'd12 + 20'd2;
    assign w_prod = 42'(w_x125) * 42'd3355444;
    assign w_q5   = w_prod[41:24];

    always_ff @(posedge i_clk) begin
        r_wts.w2   <= 19'(w_s * 20'sd2 - 20'sd65536);
        r_wts.w3   <= 19'(w_s * 20'sd3 - 20'sd65536);
        r_wts.w4   <= 19'(w_s * 20'sd4 - 20'sd65536);
        r_wts.m2   <= 19'(20'sd65536 - w_s * 20'sd2);
        r_wts.m4   <= 19'(20'sd65536 - w_s * 20'sd4);
        r_wts.w125 <= signed'({1'b0, w_q5}) - 19'sd65536;
        r_wts.w512 <= 19'(w_s - 20'sd27307);
        r_wts.q    <= 19'(20'sd16384 - w_s);
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= i_mode;
        r1_rv   <= i_vector_r;
        r1_ra   <= i_axial_r;
        r1_tv   <= i_vector_t;
        r1_ta   <= i_axial_t;
        r1_lam  <= i_lambda_factor;
        r1_sm   <= i_s_minus;
        r1_cm   <= i_c_minus;
        r1_bm   <= i_b_minus;
        r1_ll   <= fx(32'(i_lambda_factor), 32'(i_lambda_factor));
        r1_lc   <= fx(32'(i_lambda_factor), 32'(i_c_minus));
    end

    always_ff @(posedge i_clk) begin
        r_bus.rv  <= r1_rv;
        r_bus.ra  <= r1_ra;
        r_bus.tv  <= r1_tv;
        r_bus.ta  <= r1_ta;
        r_bus.lam <= r1_lam;
        r_bus.sm  <= r1_sm;
        r_bus.cm  <= r1_cm;
        r_bus.ll  <= r1_ll;
        r_bus.lc2 <= sat33(33'(r1_lc) - 33'(r1_bm) * 33'sd2);
        r_bus.lc3 <= sat33(33'(r1_lc) - 33'(r1_bm) * 33'sd3);
        r_bus.lc5 <= sat33(33'(r1_lc) - 33'(r1_bm) * 33'sd5);
        r_ctrl    <= decode(r1_mode);
    end

    assign o_bus  = r_bus;
    assign o_ctrl = r_ctrl;
    assign o_wts  = r_wts;

endmodule

`default_nettype wire

// ----- rtl/rha_lane.sv -----
// ----------------------------------------------------------------------------
// rha_lane
// One amplitude: two chained product terms, signed sum, optional weak factor.
// ----------------------------------------------------------------------------
`default_nettype none

module rha_lane (
    input  logic                  i_clk,
    input  rha_pkg::t_amp         i_amp,
    input  rha_pkg::t_bus         i_bus,
    input  rha_pkg::t_wts         i_wts,
    output logic signed [31:0]    o_amp
);
    import rha_pkg::*;

    t_amp               r_a_ctl, r_b_ctl, r_c_ctl;
    t_bus               r_a_bus;
    t_opnd              r_d_post;
    logic signed [31:0] r_a_p [2];
    logic signed [31:0] r_b_p [2];
    logic signed [31:0] r_c_p [2];
    logic signed [31:0] r_d_sum;
    logic signed [31:0] r_e;
    logic signed [31:0] n_v [2];
    logic signed [32:0] n_sum;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_v[i] = r_c_ctl.trm[i].neg ? -r_c_p[i] : r_c_p[i];
        end
        n_sum = 33'(n_v[0]) + 33'(n_v[1]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_a_p[i] <= fx(signed'({14'd0, i_amp.trm[i].coef}),
                           sel(i_amp.trm[i].x, i_bus, i_wts));
            r_b_p[i] <= fx(r_a_p[i], sel(r_a_ctl.trm[i].y, r_a_bus, i_wts));
            r_c_p[i] <= fx(r_b_p[i], sel_wt(r_b_ctl.trm[i].z, i_wts));
        end
        r_a_ctl  <= i_amp;
        r_a_bus  <= i_bus;
        r_b_ctl  <= r_a_ctl;
        r_c_ctl  <= r_b_ctl;
        r_d_sum  <= sat33(n_sum);
        r_d_post <= r_c_ctl.post;
        r_e      <= fx(r_d_sum, sel_wt(r_d_post, i_wts));
    end

    assign o_amp = r_e;

endmodule

`default_nettype wire

// ----- rtl/resonance_helicity_amplitudes.sv -----
// ----------------------------------------------------------------------------
// resonance_helicity_amplitudes
// Neutral-current resonance helicity amplitudes on a proton, Q8.16 pipeline.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  command   | start / busy              | i_mode, eight Q8.16 form factors
//  result    | o_done strobe             | twelve Q8.16 amplitudes
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_data (sin^2 weak angle)
//
//  One transaction per cycle; o_done marks the result once it has passed
//  eight register stages: two operand, three product, sum, weak factor and
//  output saturation.
//  busy never rises and the result side never stalls.
//  Synchronous reset clears the valid line and loads sin^2 = 15152.
//  Weak factors follow a config write via the sin^2 and weak-factor registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "resonance_helicity_amplitudes_macros.svh"

module resonance_helicity_amplitudes (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         i_mode,
    input  logic signed [23:0] i_vector_r,
    input  logic signed [23:0] i_axial_r,
    input  logic signed [23:0] i_vector_t,
    input  logic signed [23:0] i_axial_t,
    input  logic signed [23:0] i_lambda_factor,
    input  logic signed [23:0] i_s_minus,
    input  logic signed [23:0] i_c_minus,
    input  logic signed [23:0] i_b_minus,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [23:0] o_vec_minus3,
    output logic signed [23:0] o_vec_minus1,
    output logic signed [23:0] o_vec_plus1,
    output logic signed [23:0] o_vec_plus3,
    output logic signed [23:0] o_vec_scalar_left_plus,
    output logic signed [23:0] o_vec_scalar_left_minus,
    output logic signed [23:0] o_ax_minus3,
    output logic signed [23:0] o_ax_minus1,
    output logic signed [23:0] o_ax_plus1,
    output logic signed [23:0] o_ax_plus3,
    output logic signed [23:0] o_ax_scalar_left_plus,
    output logic signed [23:0] o_ax_scalar_left_minus
);
    import rha_pkg::*;

    logic [15:0]             r_sin2;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic [PIPE_DEPTH-2:0]   r_odd;
    logic signed [23:0]      r_res [12];
    logic                    w_accept;
    t_bus                    w_bus;
    t_ctrl                   w_ctrl;
    t_wts                    w_wts;
    logic signed [31:0]      w_amp [6];
    logic signed [31:0]      n_amp [12];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin2 <= 16'd15152;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sin2 <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_odd <= {r_odd[PIPE_DEPTH-3:0], is_odd(i_mode)};
    end

    rha_front u_front (
        .i_clk           (i_clk),
        .i_mode          (i_mode),
        .i_vector_r      (i_vector_r),
        .i_axial_r       (i_axial_r),
        .i_vector_t      (i_vector_t),
        .i_axial_t       (i_axial_t),
        .i_lambda_factor (i_lambda_factor),
        .i_s_minus       (i_s_minus),
        .i_c_minus       (i_c_minus),
        .i_b_minus       (i_b_minus),
        .i_sin2          (r_sin2),
        .o_bus           (w_bus),
        .o_ctrl          (w_ctrl),
        .o_wts           (w_wts)
    );

    for (genvar k = 0; k < 6; k++) begin : g_lane
        rha_lane u_lane (
            .i_clk (i_clk),
            .i_amp (w_ctrl.amp[k]),
            .i_bus (w_bus),
            .i_wts (w_wts),
            .o_amp (w_amp[k])
        );
    end

    // mirror: odd parity negates vector, even parity negates axial
    always_comb begin
        n_amp[0]  = w_amp[A_VM3];
        n_amp[1]  = w_amp[A_VM1];
        n_amp[4]  = w_amp[A_VL];
        n_amp[6]  = w_amp[A_AM3];
        n_amp[7]  = w_amp[A_AM1];
        n_amp[10] = w_amp[A_AL];
        if (r_odd[PIPE_DEPTH-2]) begin
            n_amp[2]  = -w_amp[A_VM1];
            n_amp[3]  = -w_amp[A_VM3];
            n_amp[5]  = -w_amp[A_VL];
            n_amp[8]  = w_amp[A_AM1];
            n_amp[9]  = w_amp[A_AM3];
            n_amp[11] = w_amp[A_AL];
        end else begin
            n_amp[2]  = w_amp[A_VM1];
            n_amp[3]  = w_amp[A_VM3];
            n_amp[5]  = w_amp[A_VL];
            n_amp[8]  = -w_amp[A_AM1];
            n_amp[9]  = -w_amp[A_AM3];
            n_amp[11] = -w_amp[A_AL];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 12; i++) begin
            r_res[i] <= sat24(n_amp[i]);
        end
    end

    assign o_done                  = r_vld[PIPE_DEPTH-1];
    assign o_vec_minus3            = r_res[0];
    assign o_vec_minus1            = r_res[1];
    assign o_vec_plus1             = r_res[2];
    assign o_vec_plus3             = r_res[3];
    assign o_vec_scalar_left_plus  = r_res[4];
    assign o_vec_scalar_left_minus = r_res[5];
    assign o_ax_minus3             = r_res[6];
    assign o_ax_minus1             = r_res[7];
    assign o_ax_plus1              = r_res[8];
    assign o_ax_plus3              = r_res[9];
    assign o_ax_scalar_left_plus   = r_res[10];
    assign o_ax_scalar_left_minus  = r_res[11];

    `RHA_ASSERT_IMP(a_done_after_start, o_done, $past(w_accept, PIPE_DEPTH))
    `RHA_ASSERT_IMP(a_unknown_zero,
        o_done && ($past(i_mode, PIPE_DEPTH) > MODE_LAST),
        o_vec_minus1 == '0 && o_vec_plus3 == '0 && o_ax_scalar_left_minus == '0)
    `RHA_ASSERT_IMP(a_s11_no_m3,
        o_done && ($past(i_mode, PIPE_DEPTH) == M_S11_1650),
        o_vec_minus3 == '0 && o_ax_plus3 == '0)
    `RHA_ASSERT_IMP(a_p33_no_vscalar,
        o_done && ($past(i_mode, PIPE_DEPTH) == M_P33_1232),
        o_vec_scalar_left_plus == '0 && o_vec_scalar_left_minus == '0)

endmodule

`default_nettype wire
